FILE: rtl/core/assert_macros.svh
// assertion macros for the unified memory port rtl
// no dependencies; the including module must have clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RVMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rvmp assertion failed");
// condition must never be seen outside reset
`define RVMP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rvmp forbidden condition seen");
`else
`define RVMP_ASSERT(lbl, prop)
`define RVMP_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/core/rvmp_pkg.sv
// shared types, codes and constants of the unified memory port
// no dependencies
package rvmp_pkg;

  // default region sizes in bytes
  localparam int unsigned ImemBytesDefault = 16384;
  localparam int unsigned DmemBytesDefault = 16384;

  // register reset values
  localparam logic [31:0] ImemBaseReset = 32'h0000_0000;
  localparam logic [31:0] DmemBaseReset = 32'h1000_0000;
  localparam logic [31:0] RxAddrReset   = 32'h2000_0000;
  localparam logic [31:0] TxAddrReset   = 32'h2000_0004;

  // config bus address width
  localparam int unsigned PAddrW = 4;

  // register indexes
  typedef enum logic [1:0] {
    REG_IMEM_BASE = 2'd0,
    REG_DMEM_BASE = 2'd1,
    REG_UART_RX   = 2'd2,
    REG_UART_TX   = 2'd3
  } reg_idx_e;

  // access modes
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_STORE = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_RX    = 2'd3
  } mode_e;

  // access sizes
  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_BAD  = 2'd3
  } size_e;

  // fetch fault codes
  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_RANGE    = 2'd1,
    FAULT_MISALIGN = 2'd2,
    FAULT_CROSS    = 2'd3
  } fault_e;

  // fetch lengths in bytes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenHalf = 3'd2;
  localparam logic [2:0] LenFull = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FIRST  = 2'd1,
    ST_SECOND = 2'd2
  } ctrl_state_e;

  // input word
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] write_value;
    logic [1:0]  size_code;
    logic [7:0]  received_byte;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  instr_length;
    logic [1:0]  fetch_fault;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } out_word_t;

  // configuration registers
  typedef struct packed {
    logic [31:0] imem_base;
    logic [31:0] dmem_base;
    logic [31:0] uart_rx_address;
    logic [31:0] uart_tx_address;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic read_next;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic straddle;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/riscv_unified_memory_port_core.sv
// top level of the unified memory port: instruction and data memory plus uart
// depends on rvmp_pkg, rvmp_regs, rvmp_ctrl, rvmp_datapath, assert_macros.svh
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | in_valid_i/in_ready_o  | in_word_i (in_word_t)
//  out      | output    | out_valid_o/out_ready_i| out_word_o (out_word_t)
//  config   | input     | apb psel/penable       | paddr, pwdata, prdata
//
// one word at a time: an accept state, then a state that forms the result;
// a standard fetch split over two memory words adds a further state for
// the second read of the single-ported memory.
// a new word is taken while the previous result waits in the output register.
// no clearing pass after reset; memories start undefined.
// a full, unread output register holds the controller before it loads.
`include "assert_macros.svh"

module riscv_unified_memory_port_core import rvmp_pkg::*; #(
  parameter int unsigned IMEM_BYTES = ImemBytesDefault,
  parameter int unsigned DMEM_BYTES = DmemBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration registers
  rvmp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  rvmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // datapath
  rvmp_datapath #(
    .IMEM_BYTES (IMEM_BYTES),
    .DMEM_BYTES (DMEM_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // checks
  `RVMP_ASSERT(a_one_word_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `RVMP_ASSERT_NEVER(a_no_overwrite, cmd.load_out && out_valid_o && !out_ready_i)
  `RVMP_ASSERT(a_out_from_load, $rose(out_valid_o) |-> $past(cmd.load_out))
  `RVMP_ASSERT(a_fault_clean, (out_valid_o && (out_word_o.fetch_fault != FAULT_NONE)) |-> ((out_word_o.read_data == '0) && (out_word_o.instr_length == LenNone)))

endmodule

FILE: rtl/core/rvmp_regs.sv
// apb configuration registers of the unified memory port
// depends on rvmp_pkg
module rvmp_regs import rvmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[PAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.imem_base       <= ImemBaseReset;
      cfg_q.dmem_base       <= DmemBaseReset;
      cfg_q.uart_rx_address <= RxAddrReset;
      cfg_q.uart_tx_address <= TxAddrReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMEM_BASE: cfg_q.imem_base       <= pwdata;
        REG_DMEM_BASE: cfg_q.dmem_base       <= pwdata;
        REG_UART_RX:   cfg_q.uart_rx_address <= pwdata;
        REG_UART_TX:   cfg_q.uart_tx_address <= pwdata;
        default:       ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_IMEM_BASE: prdata = cfg_q.imem_base;
      REG_DMEM_BASE: prdata = cfg_q.dmem_base;
      REG_UART_RX:   prdata = cfg_q.uart_rx_address;
      REG_UART_TX:   prdata = cfg_q.uart_tx_address;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/rvmp_ctrl.sv
// sequencing controller of the unified memory port
// depends on rvmp_pkg
module rvmp_ctrl import rvmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FIRST;
      end
      ST_FIRST: begin
        if (status_i.straddle) begin
          state_d = ST_SECOND;
        end else if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.read_next = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_FIRST: begin
        cmd_o.read_next = status_i.straddle;
        cmd_o.load_out  = !status_i.straddle && status_i.out_free;
      end
      ST_SECOND: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/rvmp_datapath.sv
// address decode, memories, uart byte holder and result register
// depends on rvmp_pkg
module rvmp_datapath import rvmp_pkg::*; #(
  parameter int unsigned IMEM_BYTES = ImemBytesDefault,
  parameter int unsigned DMEM_BYTES = DmemBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  in_word_t   in_word_i,
  input  cfg_t       cfg_i,
  input  logic       out_ready_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_word_t  out_word_o
);

  localparam int unsigned ImemWords = (IMEM_BYTES + 3) / 4;
  localparam int unsigned DmemWords = (DMEM_BYTES + 3) / 4;
  localparam int unsigned ImemAw    = $clog2(ImemWords);
  localparam int unsigned DmemAw    = $clog2(DmemWords);
  localparam int unsigned MaxBytes  = (IMEM_BYTES > DMEM_BYTES) ? IMEM_BYTES : DMEM_BYTES;
  localparam int unsigned OffW      = $clog2(MaxBytes + 4);
  localparam logic [OffW-1:0] ImemSize = OffW'(IMEM_BYTES);
  localparam logic [OffW-1:0] DmemSize = OffW'(DMEM_BYTES);

  // memories and read data
  logic [31:0] imem_q [ImemWords];
  logic [31:0] dmem_q [DmemWords];
  logic [31:0] imem_rdata_q, dmem_rdata_q;

  // held item
  logic [1:0]      mode_q, size_q;
  logic            imem_sel_q, mapped_q, odd_q, rx_hit_q, tx_q, second_q;
  logic [OffW-1:0] off_q;
  logic [7:0]      rx_data_q, tx_byte_q;
  logic [15:0]     low_q;

  // uart receive holder
  logic       rx_full_q;
  logic [7:0] rx_byte_q;

  // result register
  logic      out_valid_q;
  out_word_t out_word_q, first_word, second_word;

  // accept-side decode
  logic [31:0]     ioff, doff, wdata;
  logic            imem_hit, dmem_hit, rx_hit, tx_hit;
  logic            is_load, is_store, is_fetch, is_rx;
  logic [1:0]      off_lo;
  logic [3:0]      be;
  logic            rd_first, store_ok;
  logic            imem_re, dmem_re, imem_we, dmem_we;
  logic [ImemAw-1:0] imem_idx;
  logic [DmemAw-1:0] dmem_idx;

  assign ioff     = in_word_i.address - cfg_i.imem_base;
  assign doff     = in_word_i.address - cfg_i.dmem_base;
  assign imem_hit = ioff < 32'(IMEM_BYTES);
  assign dmem_hit = !imem_hit && (doff < 32'(DMEM_BYTES));
  assign rx_hit   = in_word_i.address == cfg_i.uart_rx_address;
  assign tx_hit   = in_word_i.address == cfg_i.uart_tx_address;
  assign is_load  = in_word_i.mode == MODE_LOAD;
  assign is_store = in_word_i.mode == MODE_STORE;
  assign is_fetch = in_word_i.mode == MODE_FETCH;
  assign is_rx    = in_word_i.mode == MODE_RX;
  assign off_lo   = imem_hit ? ioff[1:0] : doff[1:0];
  assign wdata    = in_word_i.write_value << {off_lo, 3'b000};

  // byte lanes of a store, cut at the word end
  always_comb begin
    case (in_word_i.size_code)
      SIZE_BYTE: be = 4'b0001 << off_lo;
      SIZE_HALF: be = 4'b0011 << off_lo;
      SIZE_WORD: be = 4'b1111;
      default:   be = 4'b0000;
    endcase
  end

  // memory port control
  assign rd_first = cmd_i.accept && ((is_load && !rx_hit) || is_fetch);
  assign store_ok = cmd_i.accept && is_store && !tx_hit && (in_word_i.size_code != SIZE_BAD);
  assign imem_re  = (rd_first && imem_hit) || (cmd_i.read_next && imem_sel_q);
  assign dmem_re  = (rd_first && dmem_hit) || (cmd_i.read_next && !imem_sel_q);
  assign imem_we  = store_ok && imem_hit;
  assign dmem_we  = store_ok && dmem_hit;
  assign imem_idx = cmd_i.accept ? ioff[ImemAw+1:2] : off_q[ImemAw+1:2] + 1'b1;
  assign dmem_idx = cmd_i.accept ? doff[DmemAw+1:2] : off_q[DmemAw+1:2] + 1'b1;

  // instruction memory
  always_ff @(posedge clk_i) begin
    if (imem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (be[b]) imem_q[imem_idx][8*b +: 8] <= wdata[8*b +: 8];
      end
    end
    if (imem_re) imem_rdata_q <= imem_q[imem_idx];
  end

  // data memory
  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (be[b]) dmem_q[dmem_idx][8*b +: 8] <= wdata[8*b +: 8];
      end
    end
    if (dmem_re) dmem_rdata_q <= dmem_q[dmem_idx];
  end

  // uart receive holder: arrival sets, load of the receive address pops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_full_q <= 1'b0;
      rx_byte_q <= '0;
    end else if (cmd_i.accept) begin
      if (is_rx) begin
        rx_full_q <= 1'b1;
        rx_byte_q <= in_word_i.received_byte;
      end else if (is_load && rx_hit) begin
        rx_full_q <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q     <= in_word_i.mode;
      size_q     <= in_word_i.size_code;
      imem_sel_q <= imem_hit;
      mapped_q   <= imem_hit || dmem_hit;
      odd_q      <= in_word_i.address[0];
      off_q      <= imem_hit ? ioff[OffW-1:0] : doff[OffW-1:0];
      rx_hit_q   <= rx_hit;
      rx_data_q  <= rx_full_q ? rx_byte_q : 8'h00;
      tx_q       <= tx_hit;
      tx_byte_q  <= in_word_i.write_value[7:0];
    end
    if (cmd_i.read_next) low_q <= first_low_half();
  end

  // phase flag: set once the second fetch word is on its way
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (cmd_i.accept) begin
      second_q <= 1'b0;
    end else if (cmd_i.read_next) begin
      second_q <= 1'b1;
    end
  end

  // result forming from the first word
  logic [31:0]     word, shifted;
  logic [15:0]     low_half;
  logic [OffW-1:0] region_size, end2, end4;
  logic            compressed, fits2, fits4;

  function automatic logic [15:0] first_low_half();
    return low_half;
  endfunction

  assign word        = imem_sel_q ? imem_rdata_q : dmem_rdata_q;
  assign shifted     = word >> {off_q[1:0], 3'b000};
  assign low_half    = off_q[1] ? word[31:16] : word[15:0];
  assign compressed  = low_half[1:0] != 2'b11;
  assign region_size = imem_sel_q ? ImemSize : DmemSize;
  assign end2        = off_q + OffW'(2);
  assign end4        = off_q + OffW'(4);
  assign fits2       = end2 <= region_size;
  assign fits4       = end4 <= region_size;

  always_comb begin
    first_word = '0;
    case (mode_q)
      MODE_LOAD: begin
        if (rx_hit_q) begin
          first_word.read_data = {24'h0, rx_data_q};
        end else if (mapped_q) begin
          case (size_q)
            SIZE_BYTE: first_word.read_data = shifted & 32'h0000_00FF;
            SIZE_HALF: first_word.read_data = shifted & 32'h0000_FFFF;
            SIZE_WORD: first_word.read_data = word;
            default:   first_word.read_data = '0;
          endcase
        end
      end
      MODE_STORE: begin
        first_word.tx_valid = tx_q;
        first_word.tx_byte  = tx_q ? tx_byte_q : 8'h00;
      end
      MODE_FETCH: begin
        if (!mapped_q) begin
          first_word.fetch_fault = FAULT_RANGE;
        end else if (odd_q) begin
          first_word.fetch_fault = FAULT_MISALIGN;
        end else if (compressed) begin
          if (!fits2) begin
            first_word.fetch_fault = FAULT_CROSS;
          end else begin
            first_word.read_data    = {16'h0, low_half};
            first_word.instr_length = LenHalf;
          end
        end else if (!fits4) begin
          first_word.fetch_fault = FAULT_CROSS;
        end else begin
          first_word.read_data    = word;
          first_word.instr_length = LenFull;
        end
      end
      default: ;
    endcase
  end

  // a standard instruction in the upper half needs the next word
  assign status_o.straddle = (mode_q == MODE_FETCH) && mapped_q && !odd_q && !compressed
                             && fits4 && off_q[1] && !second_q;

  // result forming from the second word
  always_comb begin
    second_word              = '0;
    second_word.read_data    = {word[15:0], low_q};
    second_word.instr_length = LenFull;
  end

  // output register
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_word_q <= second_q ? second_word : first_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
